[hw/rtl/mqd_pkg.sv]
package mqd_pkg;

  localparam int NumVars      = 128;
  localparam int BlockBits    = 128;
  localparam int WordW        = 64;
  localparam int StateWords   = NumVars / WordW;
  localparam int BlockWords   = BlockBits / WordW;
  localparam int EntryWords   = StateWords + BlockWords;
  localparam int TableEntries = 1 + (NumVars * (NumVars + 1)) / 2;
  localparam int EntryW       = $clog2(TableEntries);
  localparam int VarW         = $clog2(NumVars);
  localparam int WordSelW     = $clog2(EntryWords);

  typedef logic [EntryW-1:0]                  entry_t;
  typedef logic [VarW-1:0]                    var_t;
  typedef logic [WordW-1:0]                   word_t;
  typedef logic [WordSelW-1:0]                word_sel_t;
  typedef logic [EntryWords-1:0][WordW-1:0]   entry_data_t;

  localparam entry_t LastEntry = EntryW'(TableEntries - 1);
  localparam var_t   VarMax    = VarW'(NumVars - 1);

  // tag that travels alongside a table read
  typedef struct packed {
    logic valid;
    logic hit;
    logic last;
  } rd_tag_t;

  typedef struct packed {
    rd_tag_t tag;
    entry_t  entry;
  } rd_req_t;

  typedef enum logic [1:0] {
    MODE_TABLE = 2'd0,
    MODE_STATE = 2'd1,
    MODE_GEN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_STRENGTH = 2'd1,
    STATUS_RESEED   = 2'd2,
    STATUS_PREDICT  = 2'd3
  } status_e;

  localparam logic [1:0] CfgIdxStrength = 2'd0;
  localparam logic [1:0] CfgIdxReseed   = 2'd1;
  localparam logic [1:0] CfgIdxPredict  = 2'd2;

endpackage

[hw/rtl/mqd_table.sv]
module mqd_table (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  mqd_pkg::entry_t      wr_entry_i,
  input  mqd_pkg::word_sel_t   wr_word_i,
  input  mqd_pkg::word_t       wr_data_i,
  input  logic                 rd_en_i,
  input  mqd_pkg::entry_t      rd_entry_i,
  output mqd_pkg::entry_data_t rd_data_o
);
  import mqd_pkg::*;

  // one row per table entry, written one word at a time
  entry_data_t mem [TableEntries];
  entry_data_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_entry_i][wr_word_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_entry_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/mqd_seq.sv]
module mqd_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mqd_pkg::NumVars-1:0] x_i,
  output mqd_pkg::rd_req_t            req_o
);
  import mqd_pkg::*;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CONST,
    SQ_TERMS
  } seq_state_e;

  seq_state_e state_q;
  entry_t     entry_q;
  var_t       j_q;
  var_t       k_q;

  // entries of the upper triangle come in row-major order, so the address
  // simply counts up while (j, k) walk the triangle
  always_comb begin
    req_o.entry     = entry_q;
    req_o.tag.valid = (state_q != SQ_IDLE);
    req_o.tag.hit   = (state_q == SQ_CONST) | (x_i[j_q] & x_i[k_q]);
    req_o.tag.last  = (state_q == SQ_TERMS) && (entry_q == LastEntry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      entry_q <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            state_q <= SQ_CONST;
            entry_q <= '0;
            j_q     <= '0;
            k_q     <= '0;
          end
        end
        SQ_CONST: begin
          state_q <= SQ_TERMS;
          entry_q <= entry_q + EntryW'(1);
        end
        SQ_TERMS: begin
          if (entry_q == LastEntry) begin
            state_q <= SQ_IDLE;
          end else begin
            entry_q <= entry_q + EntryW'(1);
            if (k_q == VarMax) begin
              j_q <= j_q + VarW'(1);
              k_q <= j_q + VarW'(1);
            end else begin
              k_q <= k_q + VarW'(1);
            end
          end
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/mqd_acc.sv]
module mqd_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  mqd_pkg::rd_tag_t     tag_i,
  input  mqd_pkg::entry_data_t rd_data_i,
  output mqd_pkg::entry_data_t acc_o,
  output logic                 done_o
);
  import mqd_pkg::*;

  // tag delayed to line up with the registered table read
  rd_tag_t     tag_q;
  entry_data_t acc_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.valid & tag_q.last;
      if (clear_i) begin
        acc_q <= '0;
      end else if (tag_q.valid && tag_q.hit) begin
        acc_q <= acc_q ^ rd_data_i;
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

[hw/rtl/mq_drbg_generate_block.sv]
// Quadratic-system random bit generator over GF(2), generate step only.
// Input transactions carry a mode in tuser: mode 0 writes one 64-bit word of
// a coefficient table entry, mode 1 writes one state word and clears the
// block counter, mode 2 generates one output block. Loads return nothing. A
// generate first checks strength, prediction resistance and the reseed
// counter; a failure returns one transaction with a zero word, tlast set
// and the status in tuser, and leaves the state alone. Otherwise the whole
// table (8257 entries) is swept in entry order, one 256-bit entry read per
// cycle from the single read port of the table memory, and the constant
// entry and every entry whose two state bits are both set are XORed into an
// accumulator. After the table reads the last entry is folded in, then the
// state is committed, and then the output register is loaded once it is free.
// One or two output transactions follow (two when bits_keep is above 64), and
// the next input transaction is taken at the earliest in the cycle after the
// last output word is loaded, once the output register is free. The table is
// not cleared at reset: every entry that a generate hits must be written first.
// Configuration writes are taken at any time but are meant to happen only
// while the block is idle.
module mq_drbg_generate_block (
  input  logic         clk_i,
  input  logic         rst_ni,

  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,

  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[13:0], load_data[77:14], strength_asked[86:78],
  // bits_keep[94:87], extra_valid[95], extra_first[159:96],
  // extra_second[223:160]
  input  logic [223:0] s_axis_tdata,
  // mode[1:0], word_sel[3:2]
  input  logic [3:0]   s_axis_tuser,

  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_word[63:0]
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);
  import mqd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT_A,
    ST_EMIT_B
  } top_state_e;

  // mask keeping the n leading (top) bits of a word, n from 0 to 64
  function automatic word_t top_mask(input logic [6:0] n);
    word_t m;
    if (n[6]) begin
      m = '1;
    end else begin
      m = ~({WordW{1'b1}} >> n);
    end
    return m;
  endfunction

  // input fields
  logic [1:0]  in_mode;
  word_sel_t   in_word_sel;
  entry_t      in_entry;
  word_t       in_load_data;
  logic [8:0]  in_strength;
  logic [7:0]  in_keep;
  logic        in_extra_valid;
  word_t       in_extra_first;
  word_t       in_extra_second;

  assign in_mode         = s_axis_tuser[1:0];
  assign in_word_sel     = s_axis_tuser[3:2];
  assign in_entry        = s_axis_tdata[13:0];
  assign in_load_data    = s_axis_tdata[77:14];
  assign in_strength     = s_axis_tdata[86:78];
  assign in_keep         = s_axis_tdata[94:87];
  assign in_extra_valid  = s_axis_tdata[95];
  assign in_extra_first  = s_axis_tdata[159:96];
  assign in_extra_second = s_axis_tdata[223:160];

  top_state_e state_q;

  // configuration registers
  logic [8:0]  inst_strength_q;
  logic [31:0] reseed_limit_q;
  logic        predict_resist_q;

  // generator state
  logic [StateWords-1:0][WordW-1:0] gen_state_q;
  logic [31:0]                      block_count_q;
  logic [NumVars-1:0]               x_q;
  logic [7:0]                       keep_q;

  // output register
  logic    out_valid_q;
  word_t   out_word_q;
  logic    out_last_q;
  status_e out_status_q;

  logic        accept;
  logic        out_free;
  logic        out_load;
  status_e     chk_status;
  logic [7:0]  keep_clamped;
  logic        gen_start;
  logic        two_words;
  word_t       mask_a;
  word_t       mask_b;
  logic [NumVars-1:0] x_d;

  rd_req_t     rd_req;
  entry_data_t rd_data;
  entry_data_t acc;
  logic        acc_done;
  logic        tbl_wr_en;

  assign out_free      = !out_valid_q || m_axis_tready;
  // a rejected generate needs the output register, so hold off while it is busy
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // error checks, in priority order
  always_comb begin
    chk_status = STATUS_OK;
    if (in_strength > inst_strength_q) begin
      chk_status = STATUS_STRENGTH;
    end else if (predict_resist_q) begin
      chk_status = STATUS_PREDICT;
    end else if (block_count_q >= reseed_limit_q) begin
      chk_status = STATUS_RESEED;
    end
  end

  // bits_keep of zero acts as one, above the block size as the block size
  always_comb begin
    keep_clamped = in_keep;
    if (in_keep == 8'd0) begin
      keep_clamped = 8'd1;
    end else if (in_keep > 8'(BlockBits)) begin
      keep_clamped = 8'(BlockBits);
    end
  end

  // optional additional input folded into the state before the sweep
  assign x_d = in_extra_valid ? (gen_state_q ^ {in_extra_second, in_extra_first})
                              : gen_state_q;

  assign gen_start = accept && (in_mode == MODE_GEN) && (chk_status == STATUS_OK);
  assign tbl_wr_en = accept && (in_mode == MODE_TABLE) && (in_entry <= LastEntry);

  assign two_words = keep_q > 8'(WordW);
  assign mask_a    = top_mask(two_words ? 7'(WordW) : keep_q[6:0]);
  assign mask_b    = top_mask(7'(keep_q - 8'(WordW)));

  // the output register takes a refused generate or a block word
  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:   out_load = accept && (in_mode == MODE_GEN) && (chk_status != STATUS_OK);
      ST_RUN:    out_load = 1'b0;
      ST_EMIT_A: out_load = out_free;
      ST_EMIT_B: out_load = out_free;
    endcase
  end

  mqd_table u_table (
    .clk_i      (clk_i),
    .wr_en_i    (tbl_wr_en),
    .wr_entry_i (in_entry),
    .wr_word_i  (in_word_sel),
    .wr_data_i  (in_load_data),
    .rd_en_i    (rd_req.tag.valid),
    .rd_entry_i (rd_req.entry),
    .rd_data_o  (rd_data)
  );

  mqd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gen_start),
    .x_i     (x_q),
    .req_o   (rd_req)
  );

  mqd_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (gen_start),
    .tag_i     (rd_req.tag),
    .rd_data_i (rd_data),
    .acc_o     (acc),
    .done_o    (acc_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      inst_strength_q  <= 9'd128;
      reseed_limit_q   <= 32'd65536;
      predict_resist_q <= 1'b0;
      gen_state_q      <= '0;
      block_count_q    <= '0;
      x_q              <= '0;
      keep_q           <= '0;
      out_valid_q      <= 1'b0;
      out_word_q       <= '0;
      out_last_q       <= 1'b0;
      out_status_q     <= STATUS_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgIdxStrength: inst_strength_q  <= cfg_data_i[8:0];
          CfgIdxReseed:   reseed_limit_q   <= cfg_data_i;
          CfgIdxPredict:  predict_resist_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (mode_e'(in_mode))
              MODE_TABLE: ;
              MODE_STATE: begin
                gen_state_q[in_word_sel[0]] <= in_load_data;
                block_count_q               <= '0;
              end
              MODE_GEN: begin
                if (chk_status != STATUS_OK) begin
                  out_word_q   <= '0;
                  out_last_q   <= 1'b1;
                  out_status_q <= chk_status;
                end else begin
                  x_q     <= x_d;
                  keep_q  <= keep_clamped;
                  state_q <= ST_RUN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          // commit the new state and count once the sweep is folded in
          if (acc_done) begin
            gen_state_q   <= acc[StateWords-1:0];
            block_count_q <= block_count_q + 32'd1;
            state_q       <= ST_EMIT_A;
          end
        end
        ST_EMIT_A: begin
          if (out_free) begin
            out_word_q   <= acc[StateWords] & mask_a;
            out_last_q   <= !two_words;
            out_status_q <= STATUS_OK;
            state_q      <= two_words ? ST_EMIT_B : ST_IDLE;
          end
        end
        ST_EMIT_B: begin
          if (out_free) begin
            out_word_q   <= acc[StateWords+1] & mask_b;
            out_last_q   <= 1'b1;
            out_status_q <= STATUS_OK;
            state_q      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

  // the sweep only runs while a generate is in flight
  a_sweep_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_req.tag.valid |-> (state_q == ST_RUN))
    else $error("table sweep active outside a generate");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == ST_RUN))
    else $error("accumulator finished outside a generate");

  // a failed check returns a single zero word
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> ((m_axis_tdata == '0) && m_axis_tlast))
    else $error("error transaction with data or without tlast");

  // the block counter only steps by one or restarts at zero
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (block_count_q != $past(block_count_q))
      |-> ((block_count_q == $past(block_count_q) + 32'd1) || (block_count_q == '0)))
    else $error("block counter jumped");

endmodule
